// ===== rtl/core/xcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// xcfd_pkg: shared types and constants for the XOR-checked frame deframer
// Holds the stage item type, status codes and frame layout constants.
// ----------------------------------------------------------------------------
package xcfd_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [3:0] FRAME_LEN = 4'd15;
  localparam logic [3:0] CHECK_POS = 4'd14;
  localparam logic [3:0] HDR_LEN   = 4'd2;
  localparam int unsigned NUM_WORDS = 3;

  // Frame result codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BAD_CHECK  = 2'd2
  } status_t;

  // Input command codes
  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_IDLE = 1'b1
  } cmd_t;

  // One request held in the input stage
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] rx_byte;
  } item_t;

endpackage

// ===== rtl/core/xcfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// xcfd_in_stage: input register of the deframer
// Captures one request per cycle unless the frame core holds back the current one, and hands it to the frame core.
// ----------------------------------------------------------------------------
module xcfd_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,   // [7:0] rx_byte
  input  logic            in_tuser,   // [0] cmd
  input  logic            take,
  output logic            stage_v,
  output xcfd_pkg::item_t stage_item
);

  logic            stage_v_r;
  logic            stage_v_nxt;
  xcfd_pkg::item_t stage_item_r;

  // Refill in the same cycle the held request is consumed
  assign in_tready = !stage_v_r || take;

  always_comb begin
    stage_v_nxt = stage_v_r;
    if (in_tvalid && in_tready) begin
      stage_v_nxt = 1'b1;
    end else if (take) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else begin
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stage_item_r.cmd     <= xcfd_pkg::cmd_t'(in_tuser);
      stage_item_r.rx_byte <= in_tdata;
    end
  end

  assign stage_v    = stage_v_r;
  assign stage_item = stage_item_r;

endmodule

// ===== rtl/core/xcfd_frame_core.sv =====
// ----------------------------------------------------------------------------
// xcfd_frame_core: frame state, checksum test and result register
// Folds each byte into the frame state; on idle judges the frame.
// ----------------------------------------------------------------------------
module xcfd_frame_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            stage_v,
  input  xcfd_pkg::item_t stage_item,
  output logic            take,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [103:0]    out_tdata   // [1:0] status, [33:2] vel_x_bits,
                                      // [65:34] vel_y_bits, [97:66] ang_vel_bits
);

  logic [3:0]  idx_r, idx_nxt;
  logic        hdr_ok_r, hdr_ok_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic [31:0] word_r [xcfd_pkg::NUM_WORDS];
  logic [31:0] word_nxt [xcfd_pkg::NUM_WORDS];
  logic [31:0] acc_r [xcfd_pkg::NUM_WORDS];
  logic [31:0] acc_nxt [xcfd_pkg::NUM_WORDS];
  logic        out_v_r, out_v_nxt;
  logic [97:0] out_d_r, out_d_nxt;

  logic              out_free;
  logic              is_idle;
  logic              idle_take;
  logic [3:0]        off;
  logic [1:0]        wsel;
  logic [4:0]        lane;
  xcfd_pkg::status_t status;

  assign out_free  = !out_v_r || out_tready;
  assign is_idle   = (stage_item.cmd == xcfd_pkg::CMD_IDLE);
  assign take      = stage_v && (!is_idle || out_free);
  assign idle_take = take && is_idle;
  assign off       = idx_r - xcfd_pkg::HDR_LEN;
  assign wsel      = off[3:2];
  assign lane      = {off[1:0], 3'b000};

  always_comb begin
    if (!hdr_ok_r || idx_r < xcfd_pkg::HDR_LEN) begin
      status = xcfd_pkg::ST_BAD_HEADER;
    end else if (chk_r != xor_r) begin
      status = xcfd_pkg::ST_BAD_CHECK;
    end else begin
      status = xcfd_pkg::ST_OK;
    end
  end

  always_comb begin
    idx_nxt    = idx_r;
    hdr_ok_nxt = hdr_ok_r;
    xor_nxt    = xor_r;
    chk_nxt    = chk_r;
    word_nxt   = word_r;
    acc_nxt    = acc_r;
    out_v_nxt  = out_v_r && !out_tready;
    out_d_nxt  = out_d_r;
    if (take) begin
      if (is_idle) begin
        if (status == xcfd_pkg::ST_OK) begin
          acc_nxt = word_r;
        end
        out_v_nxt  = 1'b1;
        out_d_nxt  = {acc_nxt[2], acc_nxt[1], acc_nxt[0], status};
        // Return per-frame state to reset
        idx_nxt    = 4'd0;
        hdr_ok_nxt = 1'b1;
        xor_nxt    = 8'd0;
        chk_nxt    = 8'd0;
        for (int i = 0; i < xcfd_pkg::NUM_WORDS; i++) begin
          word_nxt[i] = 32'd0;
        end
      end else if (idx_r < xcfd_pkg::FRAME_LEN) begin
        if (idx_r < xcfd_pkg::HDR_LEN) begin
          if (stage_item.rx_byte != xcfd_pkg::HDR_BYTE) begin
            hdr_ok_nxt = 1'b0;
          end
        end else if (idx_r < xcfd_pkg::CHECK_POS) begin
          xor_nxt = xor_r ^ stage_item.rx_byte;
          word_nxt[wsel][lane +: 8] = word_r[wsel][lane +: 8] | stage_item.rx_byte;
        end else begin
          chk_nxt = stage_item.rx_byte;
        end
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= 4'd0;
      hdr_ok_r <= 1'b1;
      xor_r    <= 8'd0;
      chk_r    <= 8'd0;
      out_v_r  <= 1'b0;
      for (int i = 0; i < xcfd_pkg::NUM_WORDS; i++) begin
        word_r[i] <= 32'd0;
        acc_r[i]  <= 32'd0;
      end
    end else begin
      idx_r    <= idx_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      xor_r    <= xor_nxt;
      chk_r    <= chk_nxt;
      out_v_r  <= out_v_nxt;
      word_r   <= word_nxt;
      acc_r    <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r <= out_d_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'd0, out_d_r};

`ifndef SYNTH
  a_idle_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    idle_take |=> out_v_r)
    else $error("idle request did not load a result");

  a_idle_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
    idle_take |=> (idx_r == 4'd0) && hdr_ok_r && (xor_r == 8'd0))
    else $error("frame state not cleared after idle");

  a_result_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(idle_take))
    else $error("result appeared without an idle request");

  a_ok_copies_words: assert property (@(posedge clk) disable iff (!rst_n)
    (idle_take && status == xcfd_pkg::ST_OK) |=> (acc_r[0] == $past(word_r[0])))
    else $error("accepted frame did not update stored words");
`endif

endmodule

// ===== rtl/core/xor_checked_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer: byte-stream deframer with XOR checksum
// Top level: input register stage feeding the frame core.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per beat. in_tuser = 0 carries a received byte in
//           in_tdata; in_tuser = 1 marks line idle and ends the frame.
//   out_* : one result per idle request, none per byte. Each result holds
//           the frame status and the three last accepted words.
// Frame: two 0xFF header bytes, twelve payload bytes (three little-endian
//   words), one byte equal to the XOR of the payload. Missing bytes count
//   as zero, bytes past the fifteenth are dropped.
// Throughput: one request per cycle, set by the single input register, except
//   while an idle request waits for the result register to be free.
// Result path: an idle request is held in the input register, then the core
//   judges the frame and loads the result register, which holds it until taken.
// Reset: all frame state and stored words clear; no result is pending.
// Stall: a held result stays until taken; bytes keep flowing meanwhile, and
//   only an idle request waits while the result register is occupied.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,    // [7:0] rx_byte
  input  logic         in_tuser,    // [0] cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata    // [1:0] status, [33:2] vel_x_bits,
                                    // [65:34] vel_y_bits, [97:66] ang_vel_bits
);

  logic            take;
  logic            stage_v;
  xcfd_pkg::item_t stage_item;

  xcfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .stage_v    (stage_v),
    .stage_item (stage_item)
  );

  xcfd_frame_core u_frame_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_v    (stage_v),
    .stage_item (stage_item),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== bench/xor_checked_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer_tb: self-checking bench for the frame deframer
// Streams byte and idle requests into the block. A local frame tracker
// predicts the status and stored words of every idle request. Each result is
// compared field by field. The run covers three idling mixes.
// ----------------------------------------------------------------------------
module xor_checked_frame_deframer_tb;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int          ITEMS_PER_PHASE = 430;

  typedef struct {
    xcfd_pkg::status_t status;
    logic [31:0]       vel_x;
    logic [31:0]       vel_y;
    logic [31:0]       ang_vel;
  } frame_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = 8'h00;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;

  xcfd_pkg::item_t pending_q[$];
  frame_result_t   frame_results_q[$];
  xcfd_pkg::item_t drv_req;
  int              send_gap_pct = 7;
  int              recv_stall_pct = 55;
  int              err_count = 0;
  int unsigned     quiet_cycles = 0;

  // frame tracker state
  logic [3:0]  frame_pos;
  logic        hdr_good;
  logic [7:0]  pay_xor;
  logic [7:0]  chk_byte;
  logic [31:0] words_asm[xcfd_pkg::NUM_WORDS];
  logic [31:0] stored_words[xcfd_pkg::NUM_WORDS];

  xor_checked_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic clear_frame_track();
    frame_pos = 4'd0;
    hdr_good  = 1'b1;
    pay_xor   = 8'h00;
    chk_byte  = 8'h00;
    for (int i = 0; i < xcfd_pkg::NUM_WORDS; i++) words_asm[i] = 32'h0;
  endtask

  // Advance the frame tracker by one accepted request.
  task automatic deframe_request(xcfd_pkg::item_t req);
    logic [3:0]    off;
    frame_result_t res;
    if (req.cmd == xcfd_pkg::CMD_BYTE) begin
      if (frame_pos < xcfd_pkg::FRAME_LEN) begin
        if (frame_pos < xcfd_pkg::HDR_LEN) begin
          if (req.rx_byte != xcfd_pkg::HDR_BYTE) hdr_good = 1'b0;
        end else if (frame_pos < xcfd_pkg::CHECK_POS) begin
          off = frame_pos - xcfd_pkg::HDR_LEN;
          pay_xor = pay_xor ^ req.rx_byte;
          words_asm[off[3:2]] = words_asm[off[3:2]] |
                                (32'(req.rx_byte) << (8 * off[1:0]));
        end else begin
          chk_byte = req.rx_byte;
        end
        frame_pos = frame_pos + 4'd1;
      end
    end else begin
      if (!hdr_good || frame_pos < xcfd_pkg::HDR_LEN) begin
        res.status = xcfd_pkg::ST_BAD_HEADER;
      end else if (chk_byte != pay_xor) begin
        res.status = xcfd_pkg::ST_BAD_CHECK;
      end else begin
        res.status = xcfd_pkg::ST_OK;
        for (int i = 0; i < xcfd_pkg::NUM_WORDS; i++) stored_words[i] = words_asm[i];
      end
      res.vel_x   = stored_words[0];
      res.vel_y   = stored_words[1];
      res.ang_vel = stored_words[2];
      frame_results_q.push_back(res);
      clear_frame_track();
    end
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_byte(logic [7:0] b);
    pending_q.push_back('{xcfd_pkg::CMD_BYTE, b});
  endtask

  task automatic push_idle();
    pending_q.push_back('{xcfd_pkg::CMD_IDLE, 8'($urandom_range(255))});
  endtask

  // Extremes, short and empty frames, a long frame and a bad header.
  task automatic queue_directed();
    logic [7:0] payload[12];
    logic [7:0] x;
    payload = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                8'h00, 8'h00, 8'h00, 8'hFF};
    x = 8'h00;
    push_idle();
    push_byte(8'hFF);
    push_idle();
    push_byte(8'hFF);
    push_byte(8'hFF);
    foreach (payload[i]) begin
      push_byte(payload[i]);
      x = x ^ payload[i];
    end
    push_byte(x);
    push_byte(8'h3C);
    push_idle();
    push_byte(8'hFF);
    push_byte(8'h00);
    push_idle();
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_idle();
  endtask

  // Mostly well-formed frames, with broken, truncated and noise frames mixed in.
  task automatic queue_frame();
    logic [7:0] body[$];
    logic [7:0] b;
    logic [7:0] x;
    int         kind;
    int         cut;
    kind = $urandom_range(99);
    x = 8'h00;
    if (kind >= 95) begin
      repeat ($urandom_range(20)) body.push_back(rand_byte());
    end else begin
      body.push_back(xcfd_pkg::HDR_BYTE);
      body.push_back(xcfd_pkg::HDR_BYTE);
      repeat (12) begin
        b = rand_byte();
        x = x ^ b;
        body.push_back(b);
      end
      if (kind >= 60 && kind < 75) x = x ^ (8'h01 << $urandom_range(7));
      body.push_back(x);
      if (kind >= 75 && kind < 85) body[$urandom_range(1)] = 8'($urandom_range(254));
      if (kind >= 85) begin
        cut = $urandom_range(14);
        while (body.size() > cut) void'(body.pop_back());
      end else if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4)) body.push_back(rand_byte());
      end
    end
    foreach (body[i]) push_byte(body[i]);
    push_idle();
  endtask

  // Driver: hold a request until taken, then load the next or drop valid.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        drv_req = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= drv_req.rx_byte;
        in_tuser  <= drv_req.cmd;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin
    frame_result_t exp_r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        deframe_request('{xcfd_pkg::cmd_t'(in_tuser), in_tdata});
      end
      if (out_tvalid && out_tready) begin
        if (frame_results_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        end else begin
          exp_r = frame_results_q.pop_front();
          check_field("status", 32'(exp_r.status), 32'(out_tdata[1:0]));
          check_field("vel_x_bits", exp_r.vel_x, out_tdata[33:2]);
          check_field("vel_y_bits", exp_r.vel_y, out_tdata[65:34]);
          check_field("ang_vel_bits", exp_r.ang_vel, out_tdata[97:66]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clear_frame_track();
    for (int i = 0; i < xcfd_pkg::NUM_WORDS; i++) stored_words[i] = 32'h0;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 7;
          recv_stall_pct = 55;
          queue_directed();
        end
        1: begin
          send_gap_pct = 55;
          recv_stall_pct = 7;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      while (pending_q.size() < ITEMS_PER_PHASE) queue_frame();
      if (ph == 0) begin
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
      end
      do @(negedge clk);
      while (pending_q.size() != 0 || in_tvalid || frame_results_q.size() != 0);
    end
    // leave room for any stray result
    repeat (20) @(negedge clk);
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
